// ----- rtl/core/tod_pkg.sv -----
// Shared types and constants for the time-of-day clock.
`default_nettype none
package tod_pkg;

    localparam int HOUR_W = 5;
    localparam int MIN_W = 6;
    localparam int SEC_W = 6;
    localparam int IDLE_W = 24;
    localparam int CFG_INDEX_W = 2;

    localparam logic [HOUR_W-1:0] LAST_HOUR = HOUR_W'(23);
    localparam logic [HOUR_W-1:0] NOON_HOUR = HOUR_W'(12);
    localparam logic [MIN_W-1:0] LAST_MINUTE = MIN_W'(59);
    localparam logic [SEC_W-1:0] LAST_SECOND = SEC_W'(59);
    localparam logic [IDLE_W-1:0] IDLE_MAX = '1;
    localparam logic [IDLE_W-1:0] IDLE_LIMIT_RESET = IDLE_W'(60000);

    localparam logic [CFG_INDEX_W-1:0] CFG_MODE_24H = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETTABLE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_LIMIT = 2'd2;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_BUTTON = 1'b1
    } tod_cmd_t;

    typedef enum logic [1:0] {
        BTN_EXIT = 2'd0,
        BTN_HOUR = 2'd1,
        BTN_MINUTE = 2'd2,
        BTN_ZERO = 2'd3
    } tod_btn_t;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_ADD_HOUR = 2'd1,
        OP_ADD_MINUTE = 2'd2,
        OP_ZERO_SEC = 2'd3
    } tod_opc_t;

    typedef struct packed {
        logic en;
        tod_opc_t code;
    } tod_op_t;

    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0] minute;
        logic [SEC_W-1:0] second;
    } tod_hms_t;

endpackage
`default_nettype wire

// ----- rtl/core/tod_time.sv -----
// Time-of-day counters (hour, minute, second, sub-second tick) and their update.
`default_nettype none
module tod_time #(
    parameter int TICKS_PER_SECOND = 1000
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  tod_pkg::tod_op_t op,
    input  logic             mode_24h,
    output tod_pkg::tod_hms_t hms_next
);
    import tod_pkg::*;

    localparam int TICK_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
    localparam logic [TICK_W-1:0] TICK_LAST = TICK_W'(TICKS_PER_SECOND - 1);

    tod_hms_t hms_reg;
    logic [TICK_W-1:0] tick_reg;
    logic [TICK_W-1:0] tick_next;
    logic [HOUR_W-1:0] hour_inc;

    function automatic logic [HOUR_W-1:0] fix_hour(input logic [HOUR_W-1:0] h,
                                                   input logic m24);
        logic [HOUR_W-1:0] r;
        r = h;
        if (!m24 && h == '0) begin
            r = NOON_HOUR;
        end
        return r;
    endfunction

    always_comb begin
        hour_inc = (hms_reg.hour == LAST_HOUR) ? '0 : hms_reg.hour + 1'b1;
        hms_next = hms_reg;
        tick_next = tick_reg;
        if (op.en) begin
            unique case (op.code)
                OP_TICK: begin
                    if (tick_reg == TICK_LAST) begin
                        tick_next = '0;
                        if (hms_reg.second == LAST_SECOND) begin
                            hms_next.second = '0;
                            if (hms_reg.minute == LAST_MINUTE) begin
                                hms_next.minute = '0;
                                hms_next.hour = hour_inc;
                            end else begin
                                hms_next.minute = hms_reg.minute + 1'b1;
                            end
                        end else begin
                            hms_next.second = hms_reg.second + 1'b1;
                        end
                    end else begin
                        tick_next = tick_reg + 1'b1;
                    end
                end
                OP_ADD_HOUR: begin
                    tick_next = '0;
                    hms_next.hour = fix_hour(hour_inc, mode_24h);
                end
                OP_ADD_MINUTE: begin
                    tick_next = '0;
                    if (hms_reg.minute == LAST_MINUTE) begin
                        hms_next.minute = '0;
                        hms_next.hour = fix_hour(hour_inc, mode_24h);
                    end else begin
                        hms_next.minute = hms_reg.minute + 1'b1;
                        hms_next.hour = fix_hour(hms_reg.hour, mode_24h);
                    end
                end
                OP_ZERO_SEC: begin
                    tick_next = '0;
                    hms_next.second = '0;
                end
                default: begin
                    tick_next = tick_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hms_reg <= '0;
            tick_reg <= '0;
        end else begin
            hms_reg <= hms_next;
            tick_reg <= tick_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/time_of_day_clock_with_set_buttons.sv -----
// Time-of-day clock with hour/minute/zero set buttons and an idle timeout.
//
// Usage:
//   Input requests (s_valid/s_ready) carry s_cmd (tick or button) and s_button.
//   Every request yields exactly one result request on m_valid/m_ready:
//   the time shown after the update plus left_by_button and timed_out flags.
//   Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
//   cfg_ready is always high. Write only while no request is in flight.
//   A taken request is held in the input register; the update pass then writes
//   its result into the result register, which drives m_valid.
//   Throughput: one request per cycle while the receiver accepts results, set
//   by the single update pass between the input register and the result register.
//   Reset (aresetn low, synchronous) sets the time to midnight, clears the
//   idle count, empties both registers and restores configuration defaults:
//   12-hour mode, settable, idle limit 60000 ticks.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more request, after which s_ready drops.
`default_nettype none
module time_of_day_clock_with_set_buttons #(
    parameter int TICKS_PER_SECOND = 1000
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_cmd,
    input  logic [1:0]                          s_button,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [tod_pkg::HOUR_W-1:0]          m_hours_shown,
    output logic [tod_pkg::MIN_W-1:0]           m_minutes_shown,
    output logic [tod_pkg::SEC_W-1:0]           m_seconds_shown,
    output logic                                m_left_by_button,
    output logic                                m_timed_out,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tod_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tod_pkg::IDLE_W-1:0]          cfg_data
);
    import tod_pkg::*;

    logic mode_24h_reg;
    logic settable_reg;
    logic [IDLE_W-1:0] idle_limit_reg;

    logic in_valid_reg;
    tod_cmd_t in_cmd_reg;
    tod_btn_t in_btn_reg;

    logic [IDLE_W-1:0] idle_reg;
    logic [IDLE_W-1:0] idle_next;
    logic [IDLE_W-1:0] idle_inc;

    logic out_valid_reg;
    logic [HOUR_W-1:0] hours_reg;
    logic [MIN_W-1:0] minutes_reg;
    logic [SEC_W-1:0] seconds_reg;
    logic left_reg;
    logic tout_reg;

    logic process;
    logic left_next;
    logic tout_next;
    logic [HOUR_W-1:0] shown_hour;
    tod_op_t op;
    tod_hms_t hms_next;

    assign process = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || process;
    assign cfg_ready = 1'b1;

    always_comb begin
        op.en = 1'b0;
        op.code = OP_TICK;
        if (in_cmd_reg == CMD_TICK) begin
            op.en = process;
        end else if (settable_reg) begin
            unique case (in_btn_reg)
                BTN_EXIT: op.en = 1'b0;
                BTN_HOUR: begin
                    op.en = process;
                    op.code = OP_ADD_HOUR;
                end
                BTN_MINUTE: begin
                    op.en = process;
                    op.code = OP_ADD_MINUTE;
                end
                BTN_ZERO: begin
                    op.en = process;
                    op.code = OP_ZERO_SEC;
                end
                default: op.en = 1'b0;
            endcase
        end
    end

    tod_time #(
        .TICKS_PER_SECOND(TICKS_PER_SECOND)
    ) u_time (
        .aclk(aclk),
        .aresetn(aresetn),
        .op(op),
        .mode_24h(mode_24h_reg),
        .hms_next(hms_next)
    );

    always_comb begin
        idle_inc = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + 1'b1;
        idle_next = '0;
        left_next = 1'b0;
        tout_next = 1'b0;
        if (in_cmd_reg == CMD_TICK) begin
            if (settable_reg) begin
                if (idle_inc >= idle_limit_reg) begin
                    tout_next = 1'b1;
                end else begin
                    idle_next = idle_inc;
                end
            end
        end else begin
            left_next = (in_btn_reg == BTN_EXIT) || !settable_reg;
        end
    end

    always_comb begin
        shown_hour = hms_next.hour;
        if (!mode_24h_reg) begin
            if (hms_next.hour >= NOON_HOUR) begin
                shown_hour = hms_next.hour - NOON_HOUR;
            end
            if (shown_hour == '0) begin
                shown_hour = NOON_HOUR;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_24h_reg <= 1'b0;
            settable_reg <= 1'b1;
            idle_limit_reg <= IDLE_LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_MODE_24H: mode_24h_reg <= cfg_data[0];
                CFG_SETTABLE: settable_reg <= cfg_data[0];
                CFG_IDLE_LIMIT: idle_limit_reg <= cfg_data;
                default: mode_24h_reg <= mode_24h_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            idle_reg <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (process) begin
                in_valid_reg <= 1'b0;
            end
            if (process) begin
                out_valid_reg <= 1'b1;
                idle_reg <= idle_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg <= tod_cmd_t'(s_cmd);
            in_btn_reg <= tod_btn_t'(s_button);
        end
        if (process) begin
            hours_reg <= shown_hour;
            minutes_reg <= hms_next.minute;
            seconds_reg <= hms_next.second;
            left_reg <= left_next;
            tout_reg <= tout_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_hours_shown = hours_reg;
    assign m_minutes_shown = minutes_reg;
    assign m_seconds_shown = seconds_reg;
    assign m_left_by_button = left_reg;
    assign m_timed_out = tout_reg;

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_left_by_button && m_timed_out))
        else $error("both prompt-end flags set");

    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_minutes_shown <= LAST_MINUTE && m_seconds_shown <= LAST_SECOND))
        else $error("minute or second out of range");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input stalled while empty");

    a_process_result: assert property (@(posedge aclk) disable iff (!aresetn)
        process |=> out_valid_reg)
        else $error("processed request produced no result");

    a_timeout_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (process && tout_next) |=> (idle_reg == '0))
        else $error("idle count not cleared on timeout");

endmodule
`default_nettype wire
